// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers, compiled out under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define OOK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define OOK_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define OOK_ASSERT(lbl, prop, msg)
`define OOK_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== hw/rtl/ookpf_pkg.sv =====
// ----------------------------------------------------------------------------
// ookpf_pkg
// Shared types, codes and helper functions of the OOK packet framer.
// ----------------------------------------------------------------------------
package ookpf_pkg;

    localparam logic [7:0] MAX_PAYLOAD = 8'd255;

    localparam logic [15:0] CRC_POLY_REFL = 16'hA001;
    localparam logic [15:0] CRC_XOROUT    = 16'hFFFF;

    localparam logic [15:0] RST_PREAMBLE    = 16'h5AA5;
    localparam logic [7:0]  RST_TRAIN_BYTE  = 8'h55;
    localparam logic [3:0]  RST_TRAIN_COUNT = 4'd4;

    localparam logic [1:0] REG_PREAMBLE    = 2'd0;
    localparam logic [1:0] REG_TRAIN_BYTE  = 2'd1;
    localparam logic [1:0] REG_TRAIN_COUNT = 2'd2;

    localparam logic [2:0] KIND_TRAIN = 3'd0;
    localparam logic [2:0] KIND_PRE   = 3'd1;
    localparam logic [2:0] KIND_LEN   = 3'd2;
    localparam logic [2:0] KIND_DATA  = 3'd3;
    localparam logic [2:0] KIND_CRC   = 3'd4;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_ABANDON = 2'd1;
    localparam logic [1:0] STAT_NO_PKT  = 2'd2;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    localparam int CMD_FIFO_DEPTH = 4;
    localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
    localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_START,
        CMD_DATA,
        CMD_NOPKT
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [1:0] status;
        logic [7:0] data;
        logic       last;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TRAIN,
        S_PRE_HI,
        S_PRE_LO,
        S_LEN,
        S_DATA,
        S_CRC_HI,
        S_CRC_LO,
        S_NOPKT
    } t_back_state;

    typedef struct packed {
        logic [15:0] preamble;
        logic [7:0]  train_byte;
        logic [3:0]  train_count;
    } t_cfg;

    function automatic logic [15:0] chips_of(input logic [7:0] b);
        logic [15:0] w;
        w = '0;
        for (int i = 0; i < 8; i++) begin
            w[2*i +: 2] = b[i] ? 2'b01 : 2'b10;
        end
        return w;
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/ookpf_front.sv =====
// ----------------------------------------------------------------------------
// ookpf_front
// Accepts input transactions, tracks the open packet and issues commands.
// ----------------------------------------------------------------------------
module ookpf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_opcode,
    input  logic [7:0]        i_length,
    input  logic [7:0]        i_byte,
    input  logic              i_full,
    output logic              o_push,
    output ookpf_pkg::t_cmd   o_cmd
);

    logic       r_open;
    logic       n_open;
    logic [7:0] r_remaining;
    logic [7:0] n_remaining;
    logic [7:0] len_sat;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign len_sat = (i_length > ookpf_pkg::MAX_PAYLOAD) ? ookpf_pkg::MAX_PAYLOAD : i_length;

    always_comb begin
        n_open      = r_open;
        n_remaining = r_remaining;
        o_cmd       = '{kind: ookpf_pkg::CMD_NOPKT, status: ookpf_pkg::STAT_NO_PKT,
                        data: 8'h00, last: 1'b0};
        if (i_opcode == ookpf_pkg::OP_START) begin
            o_cmd.kind   = ookpf_pkg::CMD_START;
            o_cmd.status = r_open ? ookpf_pkg::STAT_ABANDON : ookpf_pkg::STAT_OK;
            o_cmd.data   = len_sat;
            o_cmd.last   = (len_sat == 8'd0);
            n_open       = (len_sat != 8'd0);
            n_remaining  = len_sat;
        end else if (r_open) begin
            o_cmd.kind   = ookpf_pkg::CMD_DATA;
            o_cmd.status = ookpf_pkg::STAT_OK;
            o_cmd.data   = i_byte;
            o_cmd.last   = (r_remaining == 8'd1);
            n_open       = (r_remaining != 8'd1);
            n_remaining  = r_remaining - 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_remaining <= 8'd0;
        end else if (o_push) begin
            r_open      <= n_open;
            r_remaining <= n_remaining;
        end
    end

endmodule

// ===== hw/rtl/ookpf_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// ookpf_cmd_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module ookpf_cmd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ookpf_pkg::t_cmd   i_cmd,
    output logic              o_full,
    output logic              o_valid,
    output ookpf_pkg::t_cmd   o_cmd,
    input  logic              i_pop
);

    ookpf_pkg::t_cmd                      r_mem [ookpf_pkg::CMD_FIFO_DEPTH];
    logic [ookpf_pkg::CMD_PTR_W-1:0]      r_wr_ptr;
    logic [ookpf_pkg::CMD_PTR_W-1:0]      r_rd_ptr;
    logic [ookpf_pkg::CMD_CNT_W-1:0]      r_count;
    logic                                 do_pop;

    assign o_full  = (r_count == ookpf_pkg::CMD_CNT_W'(ookpf_pkg::CMD_FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hw/rtl/ookpf_back.sv =====
// ----------------------------------------------------------------------------
// ookpf_back
// Expands commands into packet bytes, runs the CRC and Manchester codes them.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ookpf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ookpf_pkg::t_cfg   i_cfg,
    input  logic              i_cmd_valid,
    input  ookpf_pkg::t_cmd   i_cmd,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [15:0]       o_chip_word,
    output logic [7:0]        o_coded_byte,
    output logic [2:0]        o_byte_kind,
    output logic [1:0]        o_status,
    output logic              o_last,
    output logic              o_eop
);

    ookpf_pkg::t_back_state r_state;
    ookpf_pkg::t_back_state n_state;
    ookpf_pkg::t_cmd        r_cmd;
    logic [3:0]             r_train_cnt;
    logic [15:0]            r_crc;
    logic [15:0]            crc_x;
    logic                   emit;
    logic                   done_cmd;

    logic [7:0]             e_byte;
    logic [2:0]             e_kind;
    logic                   e_last;
    logic                   e_eop;
    logic                   e_track;
    logic [15:0]            e_crc_base;

    logic                   r_out_valid;
    logic [15:0]            r_chip;
    logic [7:0]             r_byte;
    logic [2:0]             r_kind;
    logic [1:0]             r_status;
    logic                   r_last;
    logic                   r_eop;

    function automatic ookpf_pkg::t_back_state first_state(input ookpf_pkg::t_cmd c,
                                                           input logic [3:0] tcount);
        ookpf_pkg::t_back_state s;
        case (c.kind)
            ookpf_pkg::CMD_START: s = (tcount != 4'd0) ? ookpf_pkg::S_TRAIN
                                                       : ookpf_pkg::S_PRE_HI;
            ookpf_pkg::CMD_DATA:  s = ookpf_pkg::S_DATA;
            default:              s = ookpf_pkg::S_NOPKT;
        endcase
        return s;
    endfunction

    assign crc_x    = r_crc ^ ookpf_pkg::CRC_XOROUT;
    assign emit     = (r_state != ookpf_pkg::S_IDLE) && (!r_out_valid || i_ready);
    assign o_pop    = i_cmd_valid && ((r_state == ookpf_pkg::S_IDLE) || done_cmd);
    assign done_cmd = emit && e_last;

    // next state
    always_comb begin
        n_state = r_state;
        if (o_pop) begin
            n_state = first_state(i_cmd, i_cfg.train_count);
        end else if (done_cmd) begin
            n_state = ookpf_pkg::S_IDLE;
        end else if (emit) begin
            case (r_state)
                ookpf_pkg::S_TRAIN: begin
                    if (r_train_cnt + 4'd1 == i_cfg.train_count) begin
                        n_state = ookpf_pkg::S_PRE_HI;
                    end
                end
                ookpf_pkg::S_PRE_HI: n_state = ookpf_pkg::S_PRE_LO;
                ookpf_pkg::S_PRE_LO: n_state = ookpf_pkg::S_LEN;
                ookpf_pkg::S_LEN:    n_state = ookpf_pkg::S_CRC_HI;
                ookpf_pkg::S_DATA:   n_state = ookpf_pkg::S_CRC_HI;
                ookpf_pkg::S_CRC_HI: n_state = ookpf_pkg::S_CRC_LO;
                default:             n_state = ookpf_pkg::S_IDLE;
            endcase
        end
    end

    // emitted byte
    always_comb begin
        e_byte     = 8'h00;
        e_kind     = ookpf_pkg::KIND_DATA;
        e_last     = 1'b0;
        e_eop      = 1'b0;
        e_track    = 1'b0;
        e_crc_base = r_crc;
        case (r_state)
            ookpf_pkg::S_TRAIN: begin
                e_byte = i_cfg.train_byte;
                e_kind = ookpf_pkg::KIND_TRAIN;
            end
            ookpf_pkg::S_PRE_HI: begin
                e_byte     = i_cfg.preamble[15:8];
                e_kind     = ookpf_pkg::KIND_PRE;
                e_track    = 1'b1;
                e_crc_base = 16'h0000;
            end
            ookpf_pkg::S_PRE_LO: begin
                e_byte  = i_cfg.preamble[7:0];
                e_kind  = ookpf_pkg::KIND_PRE;
                e_track = 1'b1;
            end
            ookpf_pkg::S_LEN: begin
                e_byte  = r_cmd.data;
                e_kind  = ookpf_pkg::KIND_LEN;
                e_track = 1'b1;
                e_last  = !r_cmd.last;
            end
            ookpf_pkg::S_DATA: begin
                e_byte  = r_cmd.data;
                e_kind  = ookpf_pkg::KIND_DATA;
                e_track = 1'b1;
                e_last  = !r_cmd.last;
            end
            ookpf_pkg::S_CRC_HI: begin
                e_byte = crc_x[15:8];
                e_kind = ookpf_pkg::KIND_CRC;
            end
            ookpf_pkg::S_CRC_LO: begin
                e_byte = crc_x[7:0];
                e_kind = ookpf_pkg::KIND_CRC;
                e_last = 1'b1;
                e_eop  = 1'b1;
            end
            ookpf_pkg::S_NOPKT: begin
                e_last = 1'b1;
            end
            default: begin
                e_byte = 8'h00;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ookpf_pkg::S_IDLE;
            r_train_cnt <= 4'd0;
            r_crc       <= 16'h0000;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_train_cnt <= 4'd0;
            end else if (emit && r_state == ookpf_pkg::S_TRAIN) begin
                r_train_cnt <= r_train_cnt + 4'd1;
            end
            if (emit && e_track) begin
                r_crc <= ookpf_pkg::crc_byte(e_crc_base, e_byte);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (emit) begin
            r_chip   <= (r_state == ookpf_pkg::S_NOPKT) ? 16'h0000 : ookpf_pkg::chips_of(e_byte);
            r_byte   <= e_byte;
            r_kind   <= e_kind;
            r_status <= r_cmd.status;
            r_last   <= e_last;
            r_eop    <= e_eop;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_chip_word  = r_chip;
    assign o_coded_byte = r_byte;
    assign o_byte_kind  = r_kind;
    assign o_status     = r_status;
    assign o_last       = r_last;
    assign o_eop        = r_eop;

    `OOK_ASSERT(a_eop_is_last, (r_out_valid && r_eop) |-> r_last, "end of packet without tlast")
    `OOK_ASSERT(a_crc_pair, (emit && r_state == ookpf_pkg::S_CRC_HI) |=> (r_state == ookpf_pkg::S_CRC_LO), "CRC high byte not followed by low byte")
    `OOK_ASSERT(a_hdr_from_start, (r_state == ookpf_pkg::S_TRAIN || r_state == ookpf_pkg::S_PRE_HI || r_state == ookpf_pkg::S_PRE_LO || r_state == ookpf_pkg::S_LEN) |-> (r_cmd.kind == ookpf_pkg::CMD_START), "header byte outside a start command")

endmodule

// ===== hw/rtl/ook_packet_framer_manchester.sv =====
// ----------------------------------------------------------------------------
// ook_packet_framer_manchester
// OOK packet framer: header, payload and CRC-16/MAXIM, Manchester coded.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// s_*      in   tuser[0] opcode; tdata[7:0] length, [15:8] payload byte
// m_*      out  tdata[15:0] chips, [23:16] byte; tuser kind/status/eop; tlast
// cfg_*    in   index 0 preamble, 1 training byte, 2 training count
//
// One output byte per cycle when the output is not stalled; a start item
// gives training_count + 3 bytes (+2 with zero length), a payload item 1 or 3.
// The back sequencer sets the rate; a command queue of four decouples the
// input side. Synchronous active-low reset; no clearing pass after reset.
// ----------------------------------------------------------------------------
module ook_packet_framer_manchester (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // payload_length, payload_byte
    input  logic [0:0]  i_s_tuser,   // opcode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // chip_word, coded_byte
    output logic [5:0]  o_m_tuser,   // byte_kind, status, end_of_packet
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    ookpf_pkg::t_cfg  r_cfg;
    ookpf_pkg::t_cmd  push_cmd;
    ookpf_pkg::t_cmd  head_cmd;
    logic             push;
    logic             full;
    logic             head_valid;
    logic             pop;
    logic [15:0]      chip_word;
    logic [7:0]       coded_byte;
    logic [2:0]       byte_kind;
    logic [1:0]       status;
    logic             eop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.preamble    <= ookpf_pkg::RST_PREAMBLE;
            r_cfg.train_byte  <= ookpf_pkg::RST_TRAIN_BYTE;
            r_cfg.train_count <= ookpf_pkg::RST_TRAIN_COUNT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ookpf_pkg::REG_PREAMBLE:    r_cfg.preamble    <= i_cfg_data;
                ookpf_pkg::REG_TRAIN_BYTE:  r_cfg.train_byte  <= i_cfg_data[7:0];
                ookpf_pkg::REG_TRAIN_COUNT: r_cfg.train_count <= i_cfg_data[3:0];
                default:                    r_cfg             <= r_cfg;
            endcase
        end
    end

    ookpf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_opcode (i_s_tuser[0]),
        .i_length (i_s_tdata[7:0]),
        .i_byte   (i_s_tdata[15:8]),
        .i_full   (full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    ookpf_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .o_valid (head_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    ookpf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cmd_valid  (head_valid),
        .i_cmd        (head_cmd),
        .o_pop        (pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_chip_word  (chip_word),
        .o_coded_byte (coded_byte),
        .o_byte_kind  (byte_kind),
        .o_status     (status),
        .o_last       (o_m_tlast),
        .o_eop        (eop)
    );

    assign o_m_tdata = {coded_byte, chip_word};
    assign o_m_tuser = {eop, status, byte_kind};

endmodule
